[sv/qat_pkg.sv]
// ----------------------------------------------------------------------------
// qat_pkg: shared types and constants of the quoted argument tokenizer
// request structs for both channels, status codes and character codes
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_QUOTE = 3'd1;
  localparam logic [2:0] ST_UNCLOSED  = 3'd2;
  localparam logic [2:0] ST_ESCAPE    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_TOO_MANY  = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;

  // input request: one character with its look-ahead
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] next_ch;
    logic       first;
  } qat_in_t;

  // result request
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       token_end;
    logic [3:0] token_number;
    logic [2:0] status;
    logic       string_end;
  } qat_out_t;

endpackage

`default_nettype wire

[sv/quoted_argument_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_core
// splits a character stream into shell-style argument tokens
// ----------------------------------------------------------------------------
// One character enters per cycle while in_stall is low and gives one result
// request; beyond that stall, the rate is limited only by the parser flag
// update, which sits in one combinational step from the state registers to a
// two-entry output buffer. Results are registered in the main entry, or in the
// skid entry while the main one is held. The input stalls only when both output buffer entries are full.
// Set first on the first character of each string; next_ch of zero marks
// the last character, which closes any open token.
`default_nettype none

module quoted_argument_tokenizer_core
  import qat_pkg::*;
#(
  parameter int MAX_TOKENS    = 16,
  parameter int MAX_TOKEN_LEN = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire qat_in_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output qat_out_t      out_req
);

  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int LEN_W = $clog2(MAX_TOKEN_LEN);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_TOKENS);
  localparam logic [CNT_W-1:0] NUM_TOP  = CNT_W'(MAX_TOKENS - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_TOKEN_LEN - 1);

  // parser state
  logic             inside_token_r, inside_token_nxt;
  logic             inside_quotes_r, inside_quotes_nxt;
  logic             escape_pending_r, escape_pending_nxt;
  logic [7:0]       opening_quote_r, opening_quote_nxt;
  logic [LEN_W-1:0] token_length_r, token_length_nxt;
  logic [CNT_W-1:0] token_count_r, token_count_nxt;

  // output buffer
  logic     main_valid_r, skid_valid_r;
  qat_out_t main_r, skid_r;
  qat_out_t res;

  logic in_acc, out_pop;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_req   = main_r;
  assign out_pop   = main_valid_r && !out_stall;

  // per-character parse
  always_comb begin
    logic             tok, quo, esc, lit, cls, emit, ended, last, blank, count_full;
    logic [7:0]       oq, c, nx;
    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] cnt, num_full;
    logic [2:0]       st;
    c     = in_req.ch;
    nx    = in_req.next_ch;
    last  = (nx == CH_NUL);
    tok   = in_req.first ? 1'b0 : inside_token_r;
    quo   = in_req.first ? 1'b0 : inside_quotes_r;
    esc   = in_req.first ? 1'b0 : escape_pending_r;
    oq    = in_req.first ? CH_NUL : opening_quote_r;
    len   = in_req.first ? '0 : token_length_r;
    cnt   = in_req.first ? '0 : token_count_r;
    st    = ST_OK;
    lit   = 1'b0;
    cls   = 1'b0;
    emit  = 1'b0;
    ended = 1'b0;
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    count_full = (cnt == CNT_MAX);

    // token number, held below the limit; clamped to at most 15 on output
    num_full = count_full ? NUM_TOP : cnt;

    // character class handling
    if (blank) begin
      if (esc) begin
        lit = 1'b1;
        esc = 1'b0;
      end else if (quo) begin
        lit = 1'b1;
      end else if (tok) begin
        cls = 1'b1;
      end
    end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
      if (esc) begin
        lit = 1'b1;
        esc = 1'b0;
      end else if (!tok) begin
        tok = 1'b1;
        quo = 1'b1;
        oq  = c;
      end else if (quo) begin
        if (c == oq) cls = 1'b1;
        else         lit = 1'b1;
      end else begin
        st = ST_BAD_QUOTE;
      end
    end else if (c == CH_BACKSLASH) begin
      if (quo && (nx != oq)) begin
        lit = 1'b1;
      end else if (esc) begin
        lit = 1'b1;
        esc = 1'b0;
      end else begin
        esc = 1'b1;
      end
    end else begin
      lit = 1'b1;
      esc = 1'b0;
    end

    // append a literal character
    if (lit) begin
      tok = 1'b1;
      if (count_full) begin
        st = ST_TOO_MANY;
      end else if (len >= LEN_FULL) begin
        st = ST_TOO_LONG;
      end else begin
        emit = 1'b1;
        len  = len + LEN_W'(1);
      end
    end

    // end of string closes an open token
    if (last && !cls && tok) begin
      if (st == ST_OK && quo)      st = ST_UNCLOSED;
      else if (st == ST_OK && esc) st = ST_ESCAPE;
      cls = 1'b1;
    end else if (last && st == ST_OK && esc) begin
      st = ST_ESCAPE;
    end

    // token end
    if (cls) begin
      if (count_full) begin
        if (st == ST_OK) st = ST_TOO_MANY;
      end else begin
        ended = 1'b1;
        cnt   = cnt + CNT_W'(1);
      end
      tok = 1'b0;
      quo = 1'b0;
      len = '0;
    end

    if (last) begin
      tok = 1'b0;
      quo = 1'b0;
      esc = 1'b0;
      len = '0;
    end

    inside_token_nxt   = tok;
    inside_quotes_nxt  = quo;
    escape_pending_nxt = esc;
    opening_quote_nxt  = oq;
    token_length_nxt   = len;
    token_count_nxt    = cnt;

    res.out_char     = emit ? c : CH_NUL;
    res.has_char     = emit;
    res.token_end    = ended;
    res.token_number = (32'(num_full) > 32'd15) ? 4'd15 : 4'(num_full);
    res.status       = st;
    res.string_end   = last;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_token_r   <= 1'b0;
      inside_quotes_r  <= 1'b0;
      escape_pending_r <= 1'b0;
      opening_quote_r  <= CH_NUL;
      token_length_r   <= '0;
      token_count_r    <= '0;
    end else if (in_acc) begin
      inside_token_r   <= inside_token_nxt;
      inside_quotes_r  <= inside_quotes_nxt;
      escape_pending_r <= escape_pending_nxt;
      opening_quote_r  <= opening_quote_nxt;
      token_length_r   <= token_length_nxt;
      token_count_r    <= token_count_nxt;
    end
  end

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (main_valid_r && !out_pop) skid_valid_r <= 1'b1;
      else                          main_valid_r <= 1'b1;
    end else if (out_pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // output buffer data
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) main_r <= skid_r;
    end else if (in_acc) begin
      if (main_valid_r && !out_pop) skid_r <= res;
      else                          main_r <= res;
    end
  end

endmodule

`default_nettype wire
